[hw/rtl/pcss_pkg.sv]
package pcss_pkg;

  // Fixed field widths of the request and result items.
  localparam int OP_W   = 2;
  localparam int POS_W  = 10;
  localparam int HAP_W  = 10;
  localparam int SITE_W = 20;
  localparam int DIV_W  = 21;
  localparam int RANK_W = 11;

  // Value of the haplotype count register after reset.
  localparam logic [RANK_W-1:0] HAP_COUNT_RESET = 11'd1024;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_ORDER  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_ALLELE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP       = 2'd2;
  localparam logic [OP_W-1:0] OP_READ        = 2'd3;

  // One entry of a sorted order: haplotype and its divergence.
  typedef struct packed {
    logic [HAP_W-1:0] hap;
    logic [DIV_W-1:0] div;
  } entry_t;

  // The u and v ranks recorded for one old position.
  typedef struct packed {
    logic [RANK_W-1:0] zero_rank;
    logic [RANK_W-1:0] one_rank;
  } ranks_t;

  // One haplotype as it leaves the read pipeline of a sweep.
  typedef struct packed {
    logic             valid;
    logic             one;
    logic [HAP_W-1:0] hap;
    logic [DIV_W-1:0] div;
  } part_item_t;

  // Pass control from the sequencer to the partition unit.
  typedef struct packed {
    logic count_start;
    logic split_start;
    logic split_mode;
  } part_ctrl_t;

endpackage

[hw/rtl/pcss_ifs.sv]
// Request channel.
interface pcss_in_if import pcss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [HAP_W-1:0]  hap_id;
  logic              allele;
  logic [SITE_W-1:0] site_index;

  modport source (output valid, op, position, hap_id, allele, site_index, input ready);
  modport sink (input valid, op, position, hap_id, allele, site_index, output ready);
endinterface

// Result channel.
interface pcss_out_if import pcss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] zero_total;
  logic [RANK_W-1:0] zero_rank;
  logic [RANK_W-1:0] one_rank;
  logic [HAP_W-1:0]  sorted_hap;
  logic [DIV_W-1:0]  match_start;

  modport source (output valid, zero_total, zero_rank, one_rank, sorted_hap, match_start,
                  input ready);
  modport sink (input valid, zero_total, zero_rank, one_rank, sorted_hap, match_start,
                output ready);
endinterface

// Configuration write channel for the haplotype count register.
interface pcss_cfg_if import pcss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] hap_count;

  modport source (output valid, hap_count, input ready);
  modport sink (input valid, hap_count, output ready);
endinterface

[hw/rtl/pcss_ram.sv]
module pcss_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; read data is registered and holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/pcss_partition.sv]
module pcss_partition import pcss_pkg::*; #(
  parameter int AW = 10,
  parameter int NW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  part_ctrl_t       ctl,
  input  logic [DIV_W-1:0] seed,
  input  part_item_t       item,
  output logic [NW-1:0]    zeros,
  output logic             nx_we,
  output logic [AW-1:0]    nx_addr,
  output entry_t           nx_data,
  output logic             rk_we,
  output logic [AW-1:0]    rk_addr,
  output ranks_t           rk_data
);

  logic [NW-1:0]    zi;
  logic [NW-1:0]    oi;
  logic [DIV_W-1:0] p;
  logic [DIV_W-1:0] q;
  logic [DIV_W-1:0] p_max;
  logic [DIV_W-1:0] q_max;
  logic [NW-1:0]    one_pos;
  logic [NW-1:0]    old_pos;

  // Running maxima of both groups and the destination slots.
  assign p_max   = (item.div > p) ? item.div : p;
  assign q_max   = (item.div > q) ? item.div : q;
  assign one_pos = zeros + oi;
  assign old_pos = zi + oi;

  // Writes of the new order entry and of the ranks at the old position.
  assign nx_we        = ctl.split_mode && item.valid;
  assign nx_addr      = item.one ? one_pos[AW-1:0] : zi[AW-1:0];
  assign nx_data.hap  = item.hap;
  assign nx_data.div  = item.one ? q_max : p_max;
  assign rk_we        = nx_we;
  assign rk_addr      = old_pos[AW-1:0];
  assign rk_data.zero_rank = RANK_W'(zi);
  assign rk_data.one_rank  = RANK_W'(one_pos);

  // Zero counting in the first pass, group counters in the second.
  always_ff @(posedge clk) begin
    if (rst) begin
      zeros <= '0;
      zi    <= '0;
      oi    <= '0;
    end else begin
      if (ctl.count_start) begin
        zeros <= '0;
      end else if (!ctl.split_mode && item.valid && !item.one) begin
        zeros <= zeros + 1'b1;
      end
      if (ctl.split_start) begin
        zi <= '0;
        oi <= '0;
      end else if (ctl.split_mode && item.valid) begin
        if (item.one) begin
          oi <= oi + 1'b1;
        end else begin
          zi <= zi + 1'b1;
        end
      end
    end
  end

  // Divergence maxima restart from the seed; after each emit the emitting group's maximum drops to zero.
  always_ff @(posedge clk) begin
    if (ctl.split_start) begin
      p <= seed;
      q <= seed;
    end else if (ctl.split_mode && item.valid) begin
      if (item.one) begin
        p <= p_max;
        q <= '0;
      end else begin
        p <= '0;
        q <= q_max;
      end
    end
  end

endmodule

[hw/rtl/pbwt_column_sort_step_unit.sv]
// Order and allele loads write memory as they are taken; a readback result passes the
// memory read register and is held in the output result register until taken.
// A sweep over n = min(hap_count, MAX_HAPS) haplotypes runs, in order,
// a counting pass, a split pass and a copy pass, each one memory read per cycle.
// Synchronous reset starts a clearing pass over all MAX_HAPS entries that writes the identity
// order with zero divergence; no request is taken until it ends.
module pbwt_column_sort_step_unit import pcss_pkg::*; #(
  parameter int MAX_HAPS  = 1024,
  parameter int SITE_BITS = 20
) (
  input logic        clk,
  input logic        rst,
  pcss_in_if.sink    item,
  pcss_out_if.source result,
  pcss_cfg_if.sink   cfg
);

  localparam int AW = (MAX_HAPS > 1) ? $clog2(MAX_HAPS) : 1;
  localparam int NW = $clog2(MAX_HAPS + 1);
  localparam logic [DIV_W-1:0] SITE_MASK =
    (SITE_BITS >= DIV_W) ? {DIV_W{1'b1}} : DIV_W'((64'd1 << SITE_BITS) - 64'd1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;
  localparam logic [2:0] ST_COPY  = 3'd5;

  logic [2:0]        state;
  logic [NW-1:0]     idx;
  logic [NW-1:0]     n_lim;
  logic [NW-1:0]     n_use;
  logic [RANK_W-1:0] hap_count;
  logic [DIV_W-1:0]  seed;
  logic              s1_vld;
  logic [AW-1:0]     s1_addr;
  logic              s2_vld;
  entry_t            s2_ent;
  logic              s2_ok;
  logic              rd_ok;
  logic              res_valid;
  logic              res_load;
  logic [RANK_W-1:0] res_zero_total;
  ranks_t            res_ranks;
  entry_t            res_ent;

  logic              item_acc;
  logic              sweep_state;
  logic              issue;
  logic              pos_ok;
  logic              hap_ok;
  logic              drained;

  logic              now_we;
  logic [AW-1:0]     now_waddr;
  entry_t            now_wdata;
  logic              now_re;
  entry_t            now_rdata;
  logic              al_we;
  logic              al_re;
  logic [AW-1:0]     al_raddr;
  logic              al_rdata;
  logic              nx_we;
  logic [AW-1:0]     nx_waddr;
  entry_t            nx_wdata;
  logic              nx_re;
  logic [AW-1:0]     nx_raddr;
  entry_t            nx_rdata;
  logic              rk_we;
  logic [AW-1:0]     rk_waddr;
  ranks_t            rk_wdata;
  logic              rk_re;
  ranks_t            rk_rdata;
  logic [NW-1:0]     zeros;
  part_ctrl_t        pctl;
  part_item_t        pitem;

  // Handshakes and request decode.
  assign item.ready  = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign item_acc    = item.valid && item.ready;
  assign pos_ok      = 32'(item.position) < 32'(MAX_HAPS);
  assign hap_ok      = 32'(item.hap_id) < 32'(MAX_HAPS);
  assign sweep_state = (state == ST_COUNT) || (state == ST_SPLIT);
  assign issue       = (sweep_state || state == ST_COPY) && (idx < n_lim);
  assign drained     = !issue && !s1_vld && !s2_vld;
  assign n_use       = (32'(hap_count) > 32'(MAX_HAPS)) ? NW'(MAX_HAPS) : NW'(hap_count);
  assign res_load    = (state == ST_READ) && (!res_valid || result.ready);

  // Current order memory: clearing pass, order loads and the copy pass write it.
  always_comb begin
    now_we    = 1'b0;
    now_waddr = '0;
    now_wdata = '0;
    case (state)
      ST_CLEAR: begin
        now_we        = 1'b1;
        now_waddr     = idx[AW-1:0];
        now_wdata.hap = HAP_W'(idx);
      end
      ST_IDLE: begin
        if (item_acc && item.op == OP_LOAD_ORDER && pos_ok) begin
          now_we        = 1'b1;
          now_waddr     = AW'(item.position);
          now_wdata.hap = item.hap_id;
        end
      end
      ST_COPY: begin
        if (s1_vld) begin
          now_we    = 1'b1;
          now_waddr = s1_addr;
          now_wdata = nx_rdata;
        end
      end
      default: begin
        now_we = 1'b0;
      end
    endcase
  end

  assign now_re   = issue && sweep_state;
  assign al_we    = item_acc && item.op == OP_LOAD_ALLELE && hap_ok;
  assign al_re    = s1_vld && sweep_state;
  assign al_raddr = AW'(now_rdata.hap);
  assign rk_re    = item_acc && item.op == OP_READ;
  assign nx_re    = rk_re || (issue && state == ST_COPY);
  assign nx_raddr = (state == ST_COPY) ? idx[AW-1:0] : AW'(item.position);

  pcss_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_HAPS), .ADDR_W(AW)) u_now_ram (
    .clk(clk), .we(now_we), .waddr(now_waddr), .wdata(now_wdata),
    .re(now_re), .raddr(idx[AW-1:0]), .rdata(now_rdata)
  );

  pcss_ram #(.WIDTH(1), .DEPTH(MAX_HAPS), .ADDR_W(AW)) u_allele_ram (
    .clk(clk), .we(al_we), .waddr(AW'(item.hap_id)), .wdata(item.allele),
    .re(al_re), .raddr(al_raddr), .rdata(al_rdata)
  );

  pcss_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_HAPS), .ADDR_W(AW)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
  );

  pcss_ram #(.WIDTH($bits(ranks_t)), .DEPTH(MAX_HAPS), .ADDR_W(AW)) u_rank_ram (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .re(rk_re), .raddr(AW'(item.position)), .rdata(rk_rdata)
  );

  // Partition unit fed by the last read stage.
  assign pctl.count_start = item_acc && item.op == OP_SWEEP;
  assign pctl.split_start = (state == ST_COUNT) && drained;
  assign pctl.split_mode  = (state == ST_SPLIT);
  assign pitem.valid      = s2_vld;
  assign pitem.one        = s2_ok && al_rdata;
  assign pitem.hap        = s2_ent.hap;
  assign pitem.div        = s2_ent.div;

  pcss_partition #(.AW(AW), .NW(NW)) u_partition (
    .clk(clk), .rst(rst), .ctl(pctl), .seed(seed), .item(pitem), .zeros(zeros),
    .nx_we(nx_we), .nx_addr(nx_waddr), .nx_data(nx_wdata),
    .rk_we(rk_we), .rk_addr(rk_waddr), .rk_data(rk_wdata)
  );

  // Sequencer, pipeline valid bits, configuration and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      n_lim     <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      res_valid <= 1'b0;
      hap_count <= HAP_COUNT_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        hap_count <= cfg.hap_count;
      end
      s1_vld <= issue;
      s2_vld <= s1_vld && sweep_state;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (idx == NW'(MAX_HAPS - 1)) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (item_acc && item.op == OP_SWEEP) begin
            idx   <= '0;
            n_lim <= n_use;
            state <= ST_COUNT;
          end else if (item_acc && item.op == OP_READ) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        ST_COUNT: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (drained) begin
            idx   <= '0;
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (drained) begin
            idx   <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (!s1_vld) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the pipeline and the result.
  always_ff @(posedge clk) begin
    if (item_acc && item.op == OP_SWEEP) begin
      seed <= (DIV_W'(item.site_index) & SITE_MASK) + 1'b1;
    end
    if (item_acc && item.op == OP_READ) begin
      rd_ok <= pos_ok;
    end
    s1_addr <= idx[AW-1:0];
    s2_ent  <= now_rdata;
    s2_ok   <= 32'(now_rdata.hap) < 32'(MAX_HAPS);
    if (res_load) begin
      res_zero_total <= RANK_W'(zeros);
      res_ranks      <= rd_ok ? rk_rdata : '0;
      res_ent        <= rd_ok ? nx_rdata : '0;
    end
  end

  assign result.valid       = res_valid;
  assign result.zero_total  = res_zero_total;
  assign result.zero_rank   = res_ranks.zero_rank;
  assign result.one_rank    = res_ranks.one_rank;
  assign result.sorted_hap  = res_ent.hap;
  assign result.match_start = res_ent.div;

  // The allele stage only ever follows a current-order read.
  assert property (@(posedge clk) disable iff (rst) s2_vld |-> $past(s1_vld))
    else $error("allele stage valid without a preceding order read");

  // A request is only taken with the sweep pipeline empty.
  assert property (@(posedge clk) disable iff (rst) item.ready |-> !s1_vld && !s2_vld)
    else $error("request taken while the sweep pipeline is busy");

  // The position walk never runs past the haplotype limit.
  assert property (@(posedge clk) disable iff (rst)
                   (sweep_state || state == ST_COPY) |-> idx <= n_lim)
    else $error("position counter beyond haplotype limit");

  // Rank writes stay inside the swept range.
  assert property (@(posedge clk) disable iff (rst) rk_we |-> NW'(rk_waddr) < n_lim)
    else $error("rank write outside the swept range");

endmodule
